@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/smkrs_pkg.sv @@
// Shared constants and types of the stable multi-key record sort.
`timescale 1ns / 1ps
`default_nettype none
package smkrs_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam int SIZE_W  = 63;
	localparam int NLEN_W  = 12;
	localparam int TIME_W  = 32;
	localparam int ID_W    = 31;
	localparam int KEY_W   = SIZE_W + NLEN_W + 3 * TIME_W;
	localparam int IN_W    = 208;
	localparam int OUT_W   = 32;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [ID_W-1:0]  id_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [6:0] {
		ST_LOAD   = 7'b0000001,
		ST_RDI    = 7'b0000010,
		ST_KEYI   = 7'b0000100,
		ST_SWEEP  = 7'b0001000,
		ST_PUT    = 7'b0010000,
		ST_OUT_RD = 7'b0100000,
		ST_OUT_ID = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

@@ src/stable_multi_key_record_sort.sv @@
// Top level of the stable multi-key record sort.
// Usage:
//   Input stream s_*: one record per item; s_tlast marks the last record of
//   a group. Up to 64 records are stored; later ones are dropped and the
//   group's results carry m_tuser = 1 (overflow).
//   Output stream m_*: the record ids of the group in ascending key order
//   (size, name length, ctime, mtime, atime), equal keys in load order;
//   m_tlast marks the final id.
//   While a group loads, s_tready stays high. After the last item the rank
//   of every record is found with a single shared key comparator, one
//   record pair per cycle. Each result then passes through a permutation
//   read, an id read and an output load. s_tready stays low from the last
//   item of a group until its final result sits in the output register.
//   A stalled receiver holds the output register and pauses result fetch.
//   Reset empties the group and the output register; the record stores need
//   no clearing, only entries written in the current group are read.
`timescale 1ns / 1ps
`default_nettype none
module stable_multi_key_record_sort (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// file_size[62:0], name_len[74:63], change_time[106:75], modify_time[138:107],
	// access_time[170:139], record_id[201:171], zero pad
	input  wire  [smkrs_pkg::IN_W-1:0]   s_tdata,
	input  wire                          s_tlast,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// sorted_id[30:0], zero pad
	output logic [smkrs_pkg::OUT_W-1:0]  m_tdata,
	output logic                         m_tlast,
	// overflow[0]
	output logic                         m_tuser
);
	import smkrs_pkg::*;

	state_t state_q;
	cnt_t   cnt_q;
	logic   drop_q;
	idx_t   i_q, j_q, k_q, rank_q;
	key_t   keyi_q;

	key_t   key_mem [DEPTH];
	id_t    id_mem [DEPTH];
	idx_t   perm_mem [DEPTH];

	key_t   key_rd_q;
	id_t    id_rd_q;
	idx_t   perm_rd_q;

	logic   out_valid_q, out_last_q, out_ovf_q, out_ld_q;
	id_t    out_id_q;

	logic   in_acc, out_acc, has_room, precedes, out_free;
	idx_t   last_idx, key_raddr;
	logic   key_ren;
	key_t   in_key;

	assign s_tready = (state_q == ST_LOAD) && !out_ld_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = out_valid_q && m_tready;
	assign out_free = !out_valid_q || m_tready;
	assign has_room = cnt_q < CNT_W'(DEPTH);
	assign last_idx = IDX_W'(cnt_q - 1'b1);

	assign in_key = {s_tdata[62:0], s_tdata[74:63], s_tdata[106:75],
		s_tdata[138:107], s_tdata[170:139]};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - ID_W){1'b0}}, out_id_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	always_comb begin
		key_ren   = 1'b0;
		key_raddr = i_q;
		case (state_q)
			ST_RDI: begin
				key_ren   = 1'b1;
				key_raddr = i_q;
			end
			ST_KEYI: begin
				key_ren   = 1'b1;
				key_raddr = '0;
			end
			ST_SWEEP: begin
				key_ren   = 1'b1;
				key_raddr = IDX_W'(j_q + 1'b1);
			end
			default: begin
				key_ren   = 1'b0;
				key_raddr = i_q;
			end
		endcase
	end

	smkrs_key_cmp u_cmp (
		.key_a    (key_rd_q),
		.idx_a    (j_q),
		.key_b    (keyi_q),
		.idx_b    (i_q),
		.precedes (precedes)
	);

	// record stores
	always_ff @(posedge clk) begin
		if (in_acc && has_room) begin
			key_mem[cnt_q[IDX_W-1:0]] <= in_key;
			id_mem[cnt_q[IDX_W-1:0]]  <= s_tdata[201:171];
		end
		if (key_ren) begin
			key_rd_q <= key_mem[key_raddr];
		end
		if (state_q == ST_PUT) begin
			perm_mem[rank_q] <= i_q;
		end
		if (state_q == ST_OUT_RD) begin
			perm_rd_q <= perm_mem[k_q];
		end
		if (state_q == ST_OUT_ID) begin
			id_rd_q <= id_mem[perm_rd_q];
		end
		if (state_q == ST_KEYI) begin
			keyi_q <= key_rd_q;
		end
		if (out_ld_q && out_free) begin
			out_id_q   <= id_rd_q;
			out_last_q <= (k_q == last_idx);
			out_ovf_q  <= drop_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
			out_ld_q    <= 1'b0;
		end else begin
			if (out_ld_q && out_free) begin
				out_valid_q <= 1'b1;
				out_ld_q    <= 1'b0;
				if (k_q == last_idx) begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
					drop_q  <= 1'b0;
				end else begin
					k_q     <= IDX_W'(k_q + 1'b1);
					state_q <= ST_OUT_RD;
				end
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							cnt_q <= CNT_W'(cnt_q + 1'b1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							i_q     <= '0;
							state_q <= ST_RDI;
						end
					end
				end
				ST_RDI: begin
					state_q <= ST_KEYI;
				end
				ST_KEYI: begin
					j_q     <= '0;
					rank_q  <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (precedes) begin
						rank_q <= IDX_W'(rank_q + 1'b1);
					end
					if (j_q == last_idx) begin
						state_q <= ST_PUT;
					end else begin
						j_q <= IDX_W'(j_q + 1'b1);
					end
				end
				ST_PUT: begin
					if (i_q == last_idx) begin
						k_q     <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						i_q     <= IDX_W'(i_q + 1'b1);
						state_q <= ST_RDI;
					end
				end
				ST_OUT_RD: begin
					if (!out_ld_q) begin
						state_q <= ST_OUT_ID;
					end
				end
				ST_OUT_ID: begin
					out_ld_q <= 1'b1;
					state_q  <= ST_OUT_RD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/smkrs_key_cmp.sv @@
// Shared compare unit: record a precedes record b in stable key order.
`timescale 1ns / 1ps
`default_nettype none
module smkrs_key_cmp (
	input  wire smkrs_pkg::key_t key_a,
	input  wire smkrs_pkg::idx_t idx_a,
	input  wire smkrs_pkg::key_t key_b,
	input  wire smkrs_pkg::idx_t idx_b,
	output logic                 precedes
);
	import smkrs_pkg::*;

	always_comb begin
		precedes = (key_a < key_b) || ((key_a == key_b) && (idx_a < idx_b));
	end

endmodule
`default_nettype wire

@@ src/smkrs_checker.sv @@
// Port-level checker for the stable multi-key record sort, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module smkrs_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_tvalid,
	input wire                         s_tready,
	input wire                         s_tlast,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire [smkrs_pkg::OUT_W-1:0]  m_tdata,
	input wire                         m_tlast,
	input wire                         m_tuser
);
	import smkrs_pkg::*;

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
	`ASSERT_NEXT(a_load_continues, clk, arst_n, s_acc && !s_tlast, s_tready)
	`ASSERT_NEXT(a_sort_blocks_input, clk, arst_n, s_acc && s_tlast, !s_tready)
	`ASSERT_NOW(a_pending_is_group_end, clk, arst_n, s_tready && m_tvalid, m_tlast)

endmodule

bind stable_multi_key_record_sort smkrs_checker u_smkrs_checker (.*);
`default_nettype wire
